// ===== hw/rtl/pcts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcts_pkg: shared types and constants of the timebase scheduler
// Time width, register map, command codes and the packed result word.
// ----------------------------------------------------------------------------
package pcts_pkg;

  // Width of the internal time base (supported range 32 to 64).
  localparam int unsigned TIME_BITS = 48;

  typedef logic [TIME_BITS-1:0] tb_time_t;

  // Register map, one register per 32-bit word.
  localparam int unsigned ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_SCANLINE_IVL = 3'd0,
    REG_IRQ_IVL      = 3'd1,
    REG_COUNTER_IVL  = 3'd2,
    REG_CHAN_EN      = 3'd3,
    REG_RELOAD_CH0   = 3'd4,
    REG_RELOAD_CH1   = 3'd5,
    REG_RELOAD_CH2   = 3'd6
  } reg_idx_e;

  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_START = 1'b1
  } cmd_e;

  localparam int unsigned NUM_CH = 3;

  localparam logic [9:0]  LINES_PER_FRAME   = 10'd525;
  localparam logic [9:0]  LAST_VISIBLE_LINE = 10'd479;
  localparam logic [3:0]  RETRACE_FLAG      = 4'd8;
  localparam logic [15:0] COUNT_STEP        = 16'd10;

  localparam logic [15:0] RST_SCANLINE_IVL = 16'd31;
  localparam logic [23:0] RST_IRQ_IVL      = 24'd54925;
  localparam logic [15:0] RST_COUNTER_IVL  = 16'd8;
  localparam logic [15:0] RST_RELOAD       = 16'hFFFF;
  localparam logic [15:0] RST_LINE_TOTAL   = 16'hFFFF;

  // Result word, lowest field in the lowest bits, padded to whole bytes.
  typedef struct packed {
    logic        pad;
    logic [15:0] count_ch2;
    logic [15:0] count_ch1;
    logic [15:0] count_ch0;
    logic [15:0] line_count;
    logic [9:0]  scanline;
    logic [3:0]  display_status;
    logic        irq_pulse;
  } result_t;

endpackage

// ===== hw/rtl/pcts_elapsed.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcts_elapsed: interval check against a reference time
// True when the time is at or after the reference and at least the interval
// has passed since it, evaluated without overflow.
// ----------------------------------------------------------------------------
module pcts_elapsed (
  input  pcts_pkg::tb_time_t now_i,
  input  pcts_pkg::tb_time_t ref_i,
  input  pcts_pkg::tb_time_t ivl_i,
  output logic               elapsed_o
);
  import pcts_pkg::*;

  tb_time_t diff;

  assign diff      = now_i - ref_i;
  assign elapsed_o = (now_i >= ref_i) && (diff >= ivl_i);

endmodule

// ===== hw/rtl/pc_timebase_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pc_timebase_scheduler: time-driven scheduler of a PC timebase
// Scanline, timer interrupt and channel counter scheduling from time samples.
// ----------------------------------------------------------------------------
// Usage:
// Each input word carries a command in s_axis_tuser_i (0 tick, 1 start) and
// the current time in microseconds in s_axis_tdata_i. A start word loads the
// three reference times. A tick word runs the scanline, interrupt and counter
// interval checks and updates the scanline, status and channel counters.
// Every input word yields exactly one output word showing the state after
// that word's updates, plus the interrupt pulse.
// The block is a two-register pipeline: the input word is captured in an
// input register, then the checks and state updates run combinationally
// and land in the output register, which holds the output word.
// Throughput is one word per cycle while the receiver does not stall, set
// by the state update loop through the three 48-bit time compares.
// When the receiver stalls, the output word holds and the input register
// still takes one more word; after that s_axis_tready_o drops.
// Reset clears the pipeline, the state and the registers to their defaults.
// The user must write the APB registers only while idle; no logic enforces it.
// ----------------------------------------------------------------------------
module pc_timebase_scheduler (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Input stream
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  logic [47:0]               s_axis_tdata_i,  // [47:0] now_us
  input  logic                      s_axis_tuser_i,  // [0] command
  // Output stream
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  // [0] irq_pulse, [4:1] display_status, [14:5] scanline, [30:15] line_count,
  // [46:31] count_ch0, [62:47] count_ch1, [78:63] count_ch2, [79] zero
  output logic [79:0]               m_axis_tdata_o,
  // Configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [pcts_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import pcts_pkg::*;

  // Configuration registers.
  logic [15:0] scan_ivl_q;
  logic [23:0] irq_ivl_q;
  logic [15:0] cnt_ivl_q;
  logic [2:0]  chan_en_q;
  logic [15:0] reload_q [NUM_CH];

  // Input register.
  logic     s1_valid_q;
  cmd_e     s1_cmd_q;
  tb_time_t s1_now_q;

  // Scheduler state.
  tb_time_t    line_ref_q, line_ref_d;
  tb_time_t    irq_ref_q, irq_ref_d;
  tb_time_t    cnt_ref_q, cnt_ref_d;
  logic [9:0]  line_q, line_d;
  logic [3:0]  status_q, status_d;
  logic [15:0] total_q, total_d;
  logic [15:0] count_q [NUM_CH];
  logic [15:0] count_d [NUM_CH];
  logic [15:0] count_base [NUM_CH];
  logic        irq_d;

  // Output register.
  logic    out_valid_q;
  result_t out_q, out_d;

  logic       out_ready;
  logic       adv;
  logic       cfg_wr;
  reg_idx_e   cfg_idx;
  logic       line_fire, irq_fire, cnt_fire;
  logic       is_tick;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_ivl_q <= RST_SCANLINE_IVL;
      irq_ivl_q  <= RST_IRQ_IVL;
      cnt_ivl_q  <= RST_COUNTER_IVL;
      chan_en_q  <= 3'd0;
      for (int i = 0; i < NUM_CH; i++) begin
        reload_q[i] <= RST_RELOAD;
      end
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SCANLINE_IVL: scan_ivl_q  <= pwdata[15:0];
        REG_IRQ_IVL:      irq_ivl_q   <= pwdata[23:0];
        REG_COUNTER_IVL:  cnt_ivl_q   <= pwdata[15:0];
        REG_CHAN_EN:      chan_en_q   <= pwdata[2:0];
        REG_RELOAD_CH0:   reload_q[0] <= pwdata[15:0];
        REG_RELOAD_CH1:   reload_q[1] <= pwdata[15:0];
        REG_RELOAD_CH2:   reload_q[2] <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SCANLINE_IVL: prdata = {16'd0, scan_ivl_q};
      REG_IRQ_IVL:      prdata = {8'd0, irq_ivl_q};
      REG_COUNTER_IVL:  prdata = {16'd0, cnt_ivl_q};
      REG_CHAN_EN:      prdata = {29'd0, chan_en_q};
      REG_RELOAD_CH0:   prdata = {16'd0, reload_q[0]};
      REG_RELOAD_CH1:   prdata = {16'd0, reload_q[1]};
      REG_RELOAD_CH2:   prdata = {16'd0, reload_q[2]};
      default:          prdata = 32'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipeline flow control. The update stage advances whenever the output
  // register is empty or being drained, and the input register refills in
  // the same cycle.
  // --------------------------------------------------------------------------
  assign out_ready       = !out_valid_q || m_axis_tready_i;
  assign adv             = s1_valid_q && out_ready;
  assign s_axis_tready_o = !s1_valid_q || out_ready;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      s1_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      s1_cmd_q <= cmd_e'(s_axis_tuser_i);
      s1_now_q <= tb_time_t'(s_axis_tdata_i);
    end
  end

  // --------------------------------------------------------------------------
  // Interval checks. The three compares run in parallel on the captured time.
  // --------------------------------------------------------------------------
  pcts_elapsed u_line_chk (
    .now_i     (s1_now_q),
    .ref_i     (line_ref_q),
    .ivl_i     (tb_time_t'(scan_ivl_q)),
    .elapsed_o (line_fire)
  );

  pcts_elapsed u_irq_chk (
    .now_i     (s1_now_q),
    .ref_i     (irq_ref_q),
    .ivl_i     (tb_time_t'(irq_ivl_q)),
    .elapsed_o (irq_fire)
  );

  pcts_elapsed u_cnt_chk (
    .now_i     (s1_now_q),
    .ref_i     (cnt_ref_q),
    .ivl_i     (tb_time_t'(cnt_ivl_q)),
    .elapsed_o (cnt_fire)
  );

  // --------------------------------------------------------------------------
  // Next state. A start word only reloads the reference times; a tick word
  // applies whichever checks fired.
  // --------------------------------------------------------------------------
  assign is_tick = (s1_cmd_q == CMD_TICK);

  always_comb begin
    line_ref_d = line_ref_q;
    irq_ref_d  = irq_ref_q;
    cnt_ref_d  = cnt_ref_q;
    line_d     = line_q;
    status_d   = status_q;
    total_d    = total_q;
    irq_d      = 1'b0;
    for (int i = 0; i < NUM_CH; i++) begin
      count_base[i] = (count_q[i] < COUNT_STEP) ? reload_q[i] : count_q[i];
      count_d[i]    = count_q[i];
    end

    if (!is_tick) begin
      line_ref_d = s1_now_q;
      irq_ref_d  = s1_now_q;
      cnt_ref_d  = s1_now_q;
    end else begin
      if (line_fire) begin
        // Wrap at the end of the frame; lines past the visible area are retrace.
        line_d     = (line_q == LINES_PER_FRAME - 10'd1) ? 10'd0 : line_q + 10'd1;
        status_d   = ((line_d > LAST_VISIBLE_LINE) ? RETRACE_FLAG : 4'd0)
                     | {3'd0, line_d[0]};
        total_d    = total_q + 16'd1;
        line_ref_d = s1_now_q;
      end
      if (chan_en_q[0] && irq_fire) begin
        irq_ref_d = s1_now_q;
        irq_d     = 1'b1;
      end
      if (cnt_fire) begin
        for (int i = 0; i < NUM_CH; i++) begin
          if (chan_en_q[i]) begin
            count_d[i] = count_base[i] - COUNT_STEP;
          end
        end
        cnt_ref_d = s1_now_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_ref_q <= '0;
      irq_ref_q  <= '0;
      cnt_ref_q  <= '0;
      line_q     <= 10'd0;
      status_q   <= 4'd0;
      total_q    <= RST_LINE_TOTAL;
      for (int i = 0; i < NUM_CH; i++) begin
        count_q[i] <= 16'd0;
      end
    end else if (adv) begin
      line_ref_q <= line_ref_d;
      irq_ref_q  <= irq_ref_d;
      cnt_ref_q  <= cnt_ref_d;
      line_q     <= line_d;
      status_q   <= status_d;
      total_q    <= total_d;
      for (int i = 0; i < NUM_CH; i++) begin
        count_q[i] <= count_d[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_comb begin
    out_d.pad            = 1'b0;
    out_d.count_ch2      = count_d[2];
    out_d.count_ch1      = count_d[1];
    out_d.count_ch0      = count_d[0];
    out_d.line_count     = total_d;
    out_d.scanline       = line_d;
    out_d.display_status = status_d;
    out_d.irq_pulse      = irq_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_line_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q < LINES_PER_FRAME)
    else $error("scanline out of frame");

  a_status_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_q == (((line_q > LAST_VISIBLE_LINE) ? RETRACE_FLAG : 4'd0) | {3'd0, line_q[0]}))
    else $error("display status does not follow scanline");

  a_total_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && is_tick && line_fire |=> total_q == $past(total_q) + 16'd1)
    else $error("line count did not advance with scanline");

  a_irq_enabled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.irq_pulse |-> chan_en_q[0])
    else $error("interrupt with channel 0 disabled");

  a_start_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && !is_tick |=> line_q == $past(line_q) && !out_q.irq_pulse)
    else $error("start word changed scheduler state");

endmodule

// ===== bench/pc_timebase_scheduler_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pc_timebase_scheduler_tb: self-checking bench for the timebase scheduler
// Drives time samples and start commands into the input stream, programs the
// interval, enable and reload registers over the APB port between phases,
// and checks every output word against a hand-typed result or a cycle-free
// model of the scanline, timer interrupt and channel counter scheduling.
// ----------------------------------------------------------------------------
module pc_timebase_scheduler_tb;
  import pcts_pkg::*;

  // Run control. The timeout is far above the slowest expected run.
  localparam int unsigned CLK_HALF_NS  = 6;
  localparam int unsigned TIMEOUT_NS   = 5_000_000;
  localparam int unsigned MAX_REPORTS  = 10;
  // The block has two pipeline registers, so once the last result is out
  // and the settle time has passed it is certainly idle.
  localparam int unsigned CFG_SETTLE   = 4;
  localparam int unsigned END_SETTLE   = 10;
  // The receiver holds off once for a long stretch after this many results.
  localparam int unsigned HOLD_AT      = 520;
  localparam int unsigned HOLD_CYCLES  = 60;
  // Register index that has no register behind it.
  localparam logic [2:0]  REG_UNMAPPED = 3'd7;

  typedef enum logic {
    ROW_WORD = 1'b0,
    ROW_REG  = 1'b1
  } row_kind_e;

  // One row of the directed table: either an input word or a register write.
  // Rows with has_exp set carry an expected result typed in by hand.
  typedef struct packed {
    row_kind_e   kind;
    logic [2:0]  reg_idx;
    logic [31:0] reg_val;
    cmd_e        cmd;
    tb_time_t    now;
    logic        has_exp;
    result_t     exp;
  } dir_row_t;

  // DUT connections.
  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [47:0]         s_axis_tdata_i;   // [47:0] now_us
  logic                s_axis_tuser_i;   // [0] command
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  // [0] irq_pulse, [4:1] display_status, [14:5] scanline, [30:15] line_count,
  // [46:31] count_ch0, [62:47] count_ch1, [78:63] count_ch2, [79] zero
  logic [79:0]         m_axis_tdata_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  // Register copies kept by the bench, updated on every APB write.
  logic [15:0] cfg_scan_ivl;
  logic [23:0] cfg_irq_ivl;
  logic [15:0] cfg_cnt_ivl;
  logic [2:0]  cfg_chan_en;
  logic [15:0] cfg_reload [NUM_CH];

  // Scheduler state as the bench expects it.
  tb_time_t    line_mark;
  tb_time_t    irq_mark;
  tb_time_t    cnt_mark;
  logic [9:0]  scan_line;
  logic [3:0]  status_nib;
  logic [15:0] lines_total;
  logic [15:0] chan_count [NUM_CH];

  // Results still owed by the block, oldest first.
  result_t     pending_results [$];

  // A hand-typed expectation travels alongside the word being offered.
  logic        drv_has_exp;
  result_t     drv_exp;

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned words_in;
  int unsigned start_words;
  int unsigned irq_count;
  int unsigned retrace_count;
  tb_time_t    clock_us;

  pc_timebase_scheduler u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_HALF_NS) clk_i = ~clk_i;
  end

  // Hard stop in case the block stops answering.
  initial begin
    #(TIMEOUT_NS);
    $display("pc_timebase_scheduler_tb failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Model of the scheduler
  // --------------------------------------------------------------------------

  // An interval has run out when the time has not gone back past the mark
  // and at least the interval lies between them. Written so it never
  // overflows, even for marks close to the top of the time range.
  function automatic logic interval_due(tb_time_t now, tb_time_t mark, tb_time_t ivl);
    return (now >= mark) && ((now - mark) >= ivl);
  endfunction

  // Applies one input word to the expected state and returns the result word
  // that the block should produce for it.
  function automatic result_t advance_timebase(cmd_e cmd, tb_time_t now);
    result_t r;
    r = '0;
    if (cmd == CMD_START) begin
      line_mark = now;
      irq_mark  = now;
      cnt_mark  = now;
    end else begin
      if (interval_due(now, line_mark, tb_time_t'(cfg_scan_ivl))) begin
        scan_line   = (scan_line == LINES_PER_FRAME - 10'd1) ? 10'd0 : scan_line + 10'd1;
        status_nib  = (scan_line > LAST_VISIBLE_LINE) ? RETRACE_FLAG : 4'd0;
        status_nib[0] = scan_line[0];
        lines_total = lines_total + 16'd1;
        line_mark   = now;
      end
      if (cfg_chan_en[0] && interval_due(now, irq_mark, tb_time_t'(cfg_irq_ivl))) begin
        irq_mark    = now;
        r.irq_pulse = 1'b1;
      end
      if (interval_due(now, cnt_mark, tb_time_t'(cfg_cnt_ivl))) begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
          if (cfg_chan_en[ch]) begin
            // A channel about to underflow restarts from its reload value first.
            if (chan_count[ch] < COUNT_STEP) chan_count[ch] = cfg_reload[ch];
            chan_count[ch] = chan_count[ch] - COUNT_STEP;
          end
        end
        cnt_mark = now;
      end
    end
    r.display_status = status_nib;
    r.scanline       = scan_line;
    r.line_count     = lines_total;
    r.count_ch0      = chan_count[0];
    r.count_ch1      = chan_count[1];
    r.count_ch2      = chan_count[2];
    return r;
  endfunction

  function automatic result_t mk_result(logic irq, logic [3:0] st, logic [9:0] ln,
                                        logic [15:0] lc, logic [15:0] c0,
                                        logic [15:0] c1, logic [15:0] c2);
    result_t r;
    r = '0;
    r.irq_pulse      = irq;
    r.display_status = st;
    r.scanline       = ln;
    r.line_count     = lc;
    r.count_ch0      = c0;
    r.count_ch1      = c1;
    r.count_ch2      = c2;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  // Compares one output word with the oldest expectation, field by field.
  task automatic check_result(result_t got);
    result_t want;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("ERROR: output word %h arrived with nothing expected", got);
      return;
    end
    want = pending_results.pop_front();
    if (got.irq_pulse !== want.irq_pulse || got.display_status !== want.display_status ||
        got.scanline !== want.scanline || got.line_count !== want.line_count ||
        got.count_ch0 !== want.count_ch0 || got.count_ch1 !== want.count_ch1 ||
        got.count_ch2 !== want.count_ch2 || got.pad !== 1'b0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("ERROR: result %0d (expected/actual): irq %0d/%0d status %h/%h line %0d/%0d",
                 results_seen, want.irq_pulse, got.irq_pulse, want.display_status,
                 got.display_status, want.scanline, got.scanline);
        $display("       lines %0d/%0d ch0 %0d/%0d ch1 %0d/%0d ch2 %0d/%0d pad 0/%0d",
                 want.line_count, got.line_count, want.count_ch0, got.count_ch0,
                 want.count_ch1, got.count_ch1, want.count_ch2, got.count_ch2, got.pad);
      end
    end
  endtask

  // Both handshakes are observed at the rising edge. The output side is
  // checked before the input side is predicted, so a word and its result can
  // never be confused even if the two fall on the same edge.
  always @(posedge clk_i) begin : monitor
    result_t predicted;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        check_result(result_t'(m_axis_tdata_o));
        results_seen++;
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        predicted = advance_timebase(cmd_e'(s_axis_tuser_i), tb_time_t'(s_axis_tdata_i));
        pending_results.push_back(drv_has_exp ? drv_exp : predicted);
        words_in++;
        if (s_axis_tuser_i == CMD_START) start_words++;
        if (predicted.irq_pulse) irq_count++;
        if (predicted.display_status[3]) retrace_count++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver
  // --------------------------------------------------------------------------

  // Drops tready at random, and once holds it low for a long stretch so the
  // pipeline fills up and the block has to stall its input.
  initial begin : receiver
    int unsigned hold_left;
    logic        hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender and register access
  // --------------------------------------------------------------------------

  // Offers one word, after random idle cycles, and returns once it is taken.
  // valid stays high afterwards; the next call or a drain decides its fate.
  task automatic send_word(cmd_e cmd, tb_time_t now, logic has_exp, result_t exp);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= 48'(now);
    s_axis_tuser_i  <= cmd;
    drv_has_exp     <= has_exp;
    drv_exp         <= exp;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  // Stops offering words and waits until every result has come back.
  task automatic wait_drained(int unsigned settle);
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // Two-phase APB write. The bench copy of the register is updated the same
  // way the block should treat it: truncated to its width, or ignored when
  // the index has no register.
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_SCANLINE_IVL: cfg_scan_ivl  = val[15:0];
      REG_IRQ_IVL:      cfg_irq_ivl   = val[23:0];
      REG_COUNTER_IVL:  cfg_cnt_ivl   = val[15:0];
      REG_CHAN_EN:      cfg_chan_en   = val[2:0];
      REG_RELOAD_CH0:   cfg_reload[0] = val[15:0];
      REG_RELOAD_CH1:   cfg_reload[1] = val[15:0];
      REG_RELOAD_CH2:   cfg_reload[2] = val[15:0];
      default: ;
    endcase
  endtask

  // One random phase: program all registers while idle, then stream words.
  // Most words are ticks that walk time forward in small steps, so the
  // scanline, interrupt and counter checks fire often. The rest are start
  // commands, late samples, restarts anywhere in the time range and long
  // forward leaps.
  task automatic run_phase(logic [15:0] scan, logic [23:0] irq, logic [15:0] cnt,
                           logic [2:0] en, logic [15:0] r0, logic [15:0] r1,
                           logic [15:0] r2, int unsigned tx, int unsigned rx,
                           int unsigned n, int unsigned step_max, int unsigned pause_at);
    tb_time_t    now;
    cmd_e        cmd;
    int unsigned pick;
    int unsigned back;
    wait_drained(CFG_SETTLE);
    tx_idle_pct = tx;
    rx_idle_pct = rx;
    write_reg(REG_SCANLINE_IVL, 32'(scan));
    write_reg(REG_IRQ_IVL,      32'(irq));
    write_reg(REG_COUNTER_IVL,  32'(cnt));
    write_reg(REG_CHAN_EN,      32'(en));
    write_reg(REG_RELOAD_CH0,   32'(r0));
    write_reg(REG_RELOAD_CH1,   32'(r1));
    write_reg(REG_RELOAD_CH2,   32'(r2));
    for (int unsigned i = 0; i < n; i++) begin
      // The sender pauses once until the block has answered everything.
      if (i == pause_at) wait_drained(0);
      pick = $urandom_range(0, 99);
      cmd  = CMD_TICK;
      if (pick < 4) begin
        cmd = CMD_START;
        now = clock_us;
      end else if (pick < 8) begin
        // Late sample: time appears to go backwards for one word.
        back = $urandom_range(1, 64);
        now  = (clock_us > tb_time_t'(back)) ? clock_us - tb_time_t'(back) : '0;
      end else if (pick < 10) begin
        clock_us = tb_time_t'({$urandom(), $urandom()});
        cmd      = CMD_START;
        now      = clock_us;
      end else if (pick < 12) begin
        clock_us = clock_us + tb_time_t'({$urandom_range(0, 255), $urandom()});
        now      = clock_us;
      end else begin
        clock_us = clock_us + tb_time_t'($urandom_range(0, step_max));
        now      = clock_us;
      end
      send_word(cmd, now, 1'b0, '0);
    end
  endtask

  function automatic logic [15:0] pick_reload();
    return $urandom_range(0, 1) ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 12));
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------

  initial begin : stimulus
    result_t  res_reset;
    result_t  res_line1;
    dir_row_t dir_rows [$];

    // Every input is known from time zero.
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = CMD_TICK;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    drv_has_exp     = 1'b0;
    drv_exp         = '0;
    tx_idle_pct     = 13;
    rx_idle_pct     = 80;
    mismatches      = 0;
    results_seen    = 0;
    words_in        = 0;
    start_words     = 0;
    irq_count       = 0;
    retrace_count   = 0;
    clock_us        = '0;

    // Register and state values after reset.
    cfg_scan_ivl  = RST_SCANLINE_IVL;
    cfg_irq_ivl   = RST_IRQ_IVL;
    cfg_cnt_ivl   = RST_COUNTER_IVL;
    cfg_chan_en   = '0;
    cfg_reload[0] = RST_RELOAD;
    cfg_reload[1] = RST_RELOAD;
    cfg_reload[2] = RST_RELOAD;
    line_mark     = '0;
    irq_mark      = '0;
    cnt_mark      = '0;
    scan_line     = '0;
    status_nib    = '0;
    lines_total   = RST_LINE_TOTAL;
    chan_count[0] = '0;
    chan_count[1] = '0;
    chan_count[2] = '0;

    // Straight out of reset nothing has elapsed: scanline 0, the line counter
    // one short of wrapping, and all channel counters at zero. After 31 us
    // the first scanline advance makes line 1, odd, and wraps the line count.
    res_reset = mk_result(1'b0, 4'd0, 10'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0);
    res_line1 = mk_result(1'b0, 4'd1, 10'd1, 16'd0,    16'd0, 16'd0, 16'd0);

    dir_rows = '{
      '{ROW_WORD, REG_UNMAPPED,     32'd0,        CMD_TICK,  48'd0,    1'b1, res_reset},
      '{ROW_WORD, REG_UNMAPPED,     32'd0,        CMD_TICK,  48'd30,   1'b1, res_reset},
      '{ROW_WORD, REG_UNMAPPED,     32'd0,        CMD_TICK,  48'd31,   1'b1, res_line1},
      // Time goes backwards: nothing fires and the marks stay where they are.
      '{ROW_WORD, REG_UNMAPPED,     32'd0,        CMD_TICK,  48'd10,   1'b1, res_line1},
      // A start only moves the marks.
      '{ROW_WORD, REG_UNMAPPED,     32'd0,        CMD_START, 48'd1000, 1'b1, res_line1},
      // Zero intervals, all channels on, reloads below and above the step.
      // The over-wide reload must be cut to 16 bits, and the write to the
      // unmapped index must change nothing.
      '{ROW_REG,  REG_SCANLINE_IVL, 32'd0,        CMD_TICK,  48'd0,    1'b0, '0},
      '{ROW_REG,  REG_IRQ_IVL,      32'd0,        CMD_TICK,  48'd0,    1'b0, '0},
      '{ROW_REG,  REG_COUNTER_IVL,  32'd0,        CMD_TICK,  48'd0,    1'b0, '0},
      '{ROW_REG,  REG_CHAN_EN,      32'd7,        CMD_TICK,  48'd0,    1'b0, '0},
      '{ROW_REG,  REG_RELOAD_CH0,   32'd5,        CMD_TICK,  48'd0,    1'b0, '0},
      '{ROW_REG,  REG_RELOAD_CH1,   32'd0,        CMD_TICK,  48'd0,    1'b0, '0},
      '{ROW_REG,  REG_RELOAD_CH2,   32'hFFFF_FFFF, CMD_TICK, 48'd0,    1'b0, '0},
      '{ROW_REG,  REG_UNMAPPED,     32'd123,      CMD_TICK,  48'd0,    1'b0, '0},
      // Every check fires unless time goes back, also twice at the same time.
      '{ROW_WORD, REG_UNMAPPED,     32'd0,        CMD_TICK,  48'd1000, 1'b0, '0},
      '{ROW_WORD, REG_UNMAPPED,     32'd0,        CMD_TICK,  48'd1000, 1'b0, '0},
      '{ROW_WORD, REG_UNMAPPED,     32'd0,        CMD_TICK,  48'd999,  1'b0, '0},
      '{ROW_WORD, REG_UNMAPPED,     32'd0,        CMD_TICK,  48'hFFFF_FFFF_FFFF, 1'b0, '0},
      '{ROW_WORD, REG_UNMAPPED,     32'd0,        CMD_START, 48'hFFFF_FFFF_FFFF, 1'b0, '0},
      '{ROW_WORD, REG_UNMAPPED,     32'd0,        CMD_TICK,  48'd0,    1'b0, '0},
      '{ROW_WORD, REG_UNMAPPED,     32'd0,        CMD_START, 48'd0,    1'b0, '0},
      // Channel 0 off means no interrupt; widest intervals.
      '{ROW_REG,  REG_CHAN_EN,      32'd6,        CMD_TICK,  48'd0,    1'b0, '0},
      '{ROW_REG,  REG_IRQ_IVL,      32'h00FF_FFFF, CMD_TICK, 48'd0,    1'b0, '0},
      '{ROW_REG,  REG_SCANLINE_IVL, 32'd65535,    CMD_TICK,  48'd0,    1'b0, '0},
      '{ROW_REG,  REG_COUNTER_IVL,  32'd65535,    CMD_TICK,  48'd0,    1'b0, '0},
      '{ROW_WORD, REG_UNMAPPED,     32'd0,        CMD_TICK,  48'd65534, 1'b0, '0},
      '{ROW_WORD, REG_UNMAPPED,     32'd0,        CMD_TICK,  48'd65535, 1'b0, '0},
      // Interrupt one microsecond short of the widest interval, then on it.
      '{ROW_REG,  REG_CHAN_EN,      32'd1,        CMD_TICK,  48'd0,    1'b0, '0},
      '{ROW_WORD, REG_UNMAPPED,     32'd0,        CMD_TICK,  48'd16777214, 1'b0, '0},
      '{ROW_WORD, REG_UNMAPPED,     32'd0,        CMD_TICK,  48'd16777215, 1'b0, '0}
    };

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table: registers are only touched once the block has drained.
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) begin
        wait_drained(CFG_SETTLE);
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      end else begin
        send_word(dir_rows[i].cmd, dir_rows[i].now, dir_rows[i].has_exp, dir_rows[i].exp);
      end
    end
    clock_us = 48'd16777215;

    // Random phases. The first runs with a zero scanline interval so that the
    // scanline moves on with almost every word. Idling goes from a slow
    // receiver, to a slow sender, to none at all.
    run_phase(16'd0, 24'd0, 16'd0, 3'd7, 16'($urandom_range(0, 30)),
              16'($urandom_range(0, 30)), 16'($urandom_range(0, 30)),
              13, 80, 240, 3, 32'hFFFF_FFFF);
    run_phase(16'd1, 24'hFF_FFFF, 16'hFFFF, 3'd5, 16'hFFFF, 16'hFFFF, 16'hFFFF,
              80, 13, 120, 4, 32'hFFFF_FFFF);
    run_phase(16'($urandom_range(0, 2)), 24'($urandom_range(0, 40)),
              16'($urandom_range(0, 20)), 3'($urandom_range(0, 7)),
              pick_reload(), pick_reload(), pick_reload(), 0, 0, 120, 8, 32'hFFFF_FFFF);
    run_phase(RST_SCANLINE_IVL, RST_IRQ_IVL, RST_COUNTER_IVL, 3'd3,
              16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
              16'($urandom_range(0, 65535)), 0, 0, 120, 40, 60);

    wait_drained(END_SETTLE);

    $display("Ran %0d words (%0d start commands) through four register settings,",
             words_in, start_words);
    $display("checking %0d results with %0d interrupts and %0d retrace lines; %0d mismatches.",
             results_seen, irq_count, retrace_count, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("pc_timebase_scheduler_tb passed");
    end else begin
      $display("pc_timebase_scheduler_tb failed");
    end
    $finish;
  end

endmodule

// ===== pc_timebase_scheduler.f =====
hw/rtl/pcts_pkg.sv
hw/rtl/pcts_elapsed.sv
hw/rtl/pc_timebase_scheduler.sv
bench/pc_timebase_scheduler_tb.sv
